/* hdl/dts_pkg.sv */
// Package for the depth-first topological sort unit.
// Holds the operation codes and the sequencer state type; no dependencies.
package dts_pkg;

  localparam logic [1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [1:0] OP_RUN_SORT = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  localparam int VERTEX_W = 7;
  localparam int TIME_W   = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_ROOT,
    ST_DISC,
    ST_STEP,
    ST_EDGE,
    ST_POP,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_EMIT_C
  } seq_state_t;

endpackage

/* hdl/dts_ram.sv */
// Simple dual-port memory with one write port and one registered read port.
// Used for the edge store, list heads, stack, order and per-vertex stores.
module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/dfs_topological_sort_unit.sv */
// Top level of the depth-first topological sort unit: sequencer and stores.
// Depends on dts_pkg and dts_ram.
//
//  channel  handshake            moves
//  in_      start / busy         operation, from and to vertex
//  out_     out_strobe (1 cycle) one sorted vertex or one error transaction
//  cfg_     cfg_valid/cfg_ready  vertex count
//
// A run tries each vertex as a root, follows edges, discovers and finishes
// vertices, then emits the results; a single sequencer drives all the memories.
// Reset clears all lists at once through valid bits. Results cannot be stalled.
module dfs_topological_sort_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_operation,
  input  logic [dts_pkg::VERTEX_W-1:0] in_from_vertex,
  input  logic [dts_pkg::VERTEX_W-1:0] in_to_vertex,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [dts_pkg::VERTEX_W-1:0] cfg_vertex_count,
  output logic       out_strobe,
  output logic [dts_pkg::VERTEX_W-1:0] out_vertex,
  output logic [dts_pkg::VERTEX_W-1:0] out_parent,
  output logic [dts_pkg::TIME_W-1:0]   out_discovery_time,
  output logic [dts_pkg::TIME_W-1:0]   out_finish_time,
  output logic       out_cycle_found,
  output logic [dts_pkg::VERTEX_W-1:0] out_back_edge_from,
  output logic [dts_pkg::VERTEX_W-1:0] out_back_edge_to,
  output logic       out_last
);
  import dts_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int DW  = $clog2(MAX_VERTICES + 1);
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int TW  = $clog2(2 * MAX_VERTICES + 1);
  localparam int XW  = DW + VERTEX_W;

  seq_state_t state_r, state_nxt;
  logic [VERTEX_W-1:0] cfg_count_r, cfg_count_nxt;
  logic [MAX_VERTICES-1:0] head_valid_r, head_valid_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] done_r, done_nxt;
  logic [CW-1:0] edges_used_r, edges_used_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] order_cnt_r, order_cnt_nxt;
  logic [DW-1:0] root_r, root_nxt;
  logic [DW-1:0] emit_idx_r, emit_idx_nxt;
  logic [TW-1:0] time_r, time_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  logic          hv_q_r;

  logic [VW-1:0] from_r, from_nxt, to_r, to_nxt;
  logic          add_ok_r, add_ok_nxt;
  logic [VW-1:0] top_v_r, top_v_nxt;
  logic [CW-1:0] top_cur_r, top_cur_nxt;
  logic [VW-1:0] dv_r, dv_nxt;
  logic [DW-1:0] dp_r, dp_nxt;
  logic [VW-1:0] ev_r, ev_nxt;

  logic [VERTEX_W-1:0] o_vertex_r, o_vertex_nxt, o_parent_r, o_parent_nxt;
  logic [TW-1:0] o_disc_r, o_disc_nxt, o_fin_r, o_fin_nxt;
  logic          o_cycle_r, o_cycle_nxt, o_last_r, o_last_nxt;
  logic [VERTEX_W-1:0] o_bf_r, o_bf_nxt, o_bt_r, o_bt_nxt;

  logic [DW-1:0] n_eff;
  logic [XW-1:0] from_x, to_x, n_x;

  logic          head_we;
  logic [VW-1:0] head_wa, head_ra;
  logic [CW-1:0] head_wd, head_q, head_val;
  logic          edge_we;
  logic [EAW-1:0] edge_wa, edge_ra;
  logic [VW+CW-1:0] edge_wd, edge_q;
  logic [VW-1:0] edge_t;
  logic [CW-1:0] edge_link;
  logic          stk_we;
  logic [VW-1:0] stk_wa, stk_ra;
  logic [VW+CW-1:0] stk_wd, stk_q;
  logic          ord_we;
  logic [VW-1:0] ord_wa, ord_ra, ord_q;
  logic          info_we;
  logic [DW+TW-1:0] info_wd, info_q;
  logic          fin_we;
  logic [VW-1:0] fin_wa;
  logic [TW-1:0] fin_wd, fin_q;

  assign n_eff = (DW'(cfg_count_r) > DW'(MAX_VERTICES) ||
                  XW'(cfg_count_r) > XW'(MAX_VERTICES)) ?
                 DW'(MAX_VERTICES) : DW'(cfg_count_r);
  assign from_x = XW'(in_from_vertex);
  assign to_x   = XW'(in_to_vertex);
  assign n_x    = XW'(n_eff);

  assign head_val  = hv_q_r ? head_q : '0;
  assign edge_t    = edge_q[VW+CW-1:CW];
  assign edge_link = edge_q[CW-1:0];

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cfg_count_nxt  = cfg_count_r;
    head_valid_nxt = head_valid_r;
    visited_nxt    = visited_r;
    done_nxt       = done_r;
    edges_used_nxt = edges_used_r;
    depth_nxt      = depth_r;
    order_cnt_nxt  = order_cnt_r;
    root_nxt       = root_r;
    emit_idx_nxt   = emit_idx_r;
    time_nxt       = time_r;
    out_strobe_nxt = 1'b0;
    from_nxt       = from_r;
    to_nxt         = to_r;
    add_ok_nxt     = add_ok_r;
    top_v_nxt      = top_v_r;
    top_cur_nxt    = top_cur_r;
    dv_nxt         = dv_r;
    dp_nxt         = dp_r;
    ev_nxt         = ev_r;
    o_vertex_nxt   = o_vertex_r;
    o_parent_nxt   = o_parent_r;
    o_disc_nxt     = o_disc_r;
    o_fin_nxt      = o_fin_r;
    o_cycle_nxt    = o_cycle_r;
    o_last_nxt     = o_last_r;
    o_bf_nxt       = o_bf_r;
    o_bt_nxt       = o_bt_r;

    head_we  = 1'b0;
    head_wa  = from_r;
    head_wd  = CW'(edges_used_r + 1'b1);
    head_ra  = dv_r;
    edge_we  = 1'b0;
    edge_wa  = EAW'(edges_used_r);
    edge_wd  = {to_r, head_val};
    edge_ra  = EAW'(top_cur_r - 1'b1);
    stk_we   = 1'b0;
    stk_wa   = VW'(depth_r - 1'b1);
    stk_wd   = {top_v_r, top_cur_r};
    stk_ra   = VW'(depth_r - 2'd2);
    ord_we   = 1'b0;
    ord_wa   = VW'(order_cnt_r);
    ord_ra   = VW'(emit_idx_r - 1'b1);
    info_we  = 1'b0;
    info_wd  = {dp_r, TW'(time_r + 1'b1)};
    fin_we   = 1'b0;
    fin_wa   = top_v_r;
    fin_wd   = TW'(time_r + 1'b1);

    unique case (state_r)
      ST_IDLE: begin
        head_ra = VW'(in_from_vertex - 1'b1);
        if (cfg_valid) begin
          cfg_count_nxt = cfg_vertex_count;
        end
        if (start) begin
          priority case (in_operation)
            OP_ADD_EDGE: begin
              from_nxt   = VW'(in_from_vertex - 1'b1);
              to_nxt     = VW'(in_to_vertex - 1'b1);
              add_ok_nxt = (from_x >= XW'(1)) && (from_x <= n_x) &&
                           (to_x >= XW'(1)) && (to_x <= n_x) &&
                           (edges_used_r < CW'(MAX_EDGES));
              state_nxt  = ST_ADD;
            end
            OP_RUN_SORT: begin
              visited_nxt   = '0;
              done_nxt      = '0;
              time_nxt      = '0;
              order_cnt_nxt = '0;
              depth_nxt     = '0;
              root_nxt      = '0;
              state_nxt     = ST_ROOT;
            end
            OP_CLEAR: begin
              head_valid_nxt = '0;
              edges_used_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        if (add_ok_r) begin
          edge_we                = 1'b1;
          head_we                = 1'b1;
          head_valid_nxt[from_r] = 1'b1;
          edges_used_nxt         = CW'(edges_used_r + 1'b1);
        end
        state_nxt = ST_IDLE;
      end
      ST_ROOT: begin
        head_ra = VW'(root_r);
        if (root_r >= n_eff) begin
          emit_idx_nxt = order_cnt_r;
          state_nxt    = ST_EMIT_A;
        end else if (visited_r[VW'(root_r)]) begin
          root_nxt = DW'(root_r + 1'b1);
        end else begin
          dv_nxt    = VW'(root_r);
          dp_nxt    = '0;
          state_nxt = ST_DISC;
        end
      end
      ST_DISC: begin
        time_nxt          = TW'(time_r + 1'b1);
        info_we           = 1'b1;
        visited_nxt[dv_r] = 1'b1;
        stk_we            = (depth_r != '0);
        top_v_nxt         = dv_r;
        top_cur_nxt       = head_val;
        depth_nxt         = DW'(depth_r + 1'b1);
        state_nxt         = ST_STEP;
      end
      ST_STEP: begin
        if (top_cur_r == '0) begin
          time_nxt             = TW'(time_r + 1'b1);
          fin_we               = 1'b1;
          done_nxt[top_v_r]    = 1'b1;
          if (order_cnt_r < DW'(MAX_VERTICES)) begin
            ord_we        = 1'b1;
            order_cnt_nxt = DW'(order_cnt_r + 1'b1);
          end
          depth_nxt = DW'(depth_r - 1'b1);
          state_nxt = (depth_r == DW'(1)) ? ST_ROOT : ST_POP;
        end else begin
          state_nxt = ST_EDGE;
        end
      end
      ST_POP: begin
        top_v_nxt   = stk_q[VW+CW-1:CW];
        top_cur_nxt = stk_q[CW-1:0];
        state_nxt   = ST_STEP;
      end
      ST_EDGE: begin
        head_ra     = edge_t;
        top_cur_nxt = edge_link;
        state_nxt   = ST_STEP;
        if (DW'(edge_t) < n_eff) begin
          if (!visited_r[edge_t]) begin
            if (depth_r < DW'(MAX_VERTICES)) begin
              dv_nxt    = edge_t;
              dp_nxt    = DW'(top_v_r + 1'b1);
              state_nxt = ST_DISC;
            end
          end else if (!done_r[edge_t]) begin
            depth_nxt      = '0;
            out_strobe_nxt = 1'b1;
            o_vertex_nxt   = '0;
            o_parent_nxt   = '0;
            o_disc_nxt     = '0;
            o_fin_nxt      = '0;
            o_cycle_nxt    = 1'b1;
            o_bf_nxt       = VERTEX_W'(top_v_r + 1'b1);
            o_bt_nxt       = VERTEX_W'(edge_t + 1'b1);
            o_last_nxt     = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      ST_EMIT_A: begin
        state_nxt = (emit_idx_r == '0) ? ST_IDLE : ST_EMIT_B;
      end
      ST_EMIT_B: begin
        ev_nxt    = ord_q;
        state_nxt = ST_EMIT_C;
      end
      ST_EMIT_C: begin
        out_strobe_nxt = 1'b1;
        o_vertex_nxt   = VERTEX_W'(ev_r + 1'b1);
        o_parent_nxt   = VERTEX_W'(info_q[DW+TW-1:TW]);
        o_disc_nxt     = info_q[TW-1:0];
        o_fin_nxt      = fin_q;
        o_cycle_nxt    = 1'b0;
        o_bf_nxt       = '0;
        o_bt_nxt       = '0;
        o_last_nxt     = (emit_idx_r == DW'(1));
        emit_idx_nxt   = DW'(emit_idx_r - 1'b1);
        state_nxt      = ST_EMIT_A;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_count_r  <= VERTEX_W'(64);
      head_valid_r <= '0;
      visited_r    <= '0;
      done_r       <= '0;
      edges_used_r <= '0;
      depth_r      <= '0;
      order_cnt_r  <= '0;
      root_r       <= '0;
      emit_idx_r   <= '0;
      time_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cfg_count_r  <= cfg_count_nxt;
      head_valid_r <= head_valid_nxt;
      visited_r    <= visited_nxt;
      done_r       <= done_nxt;
      edges_used_r <= edges_used_nxt;
      depth_r      <= depth_nxt;
      order_cnt_r  <= order_cnt_nxt;
      root_r       <= root_nxt;
      emit_idx_r   <= emit_idx_nxt;
      time_r       <= time_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hv_q_r     <= head_valid_r[head_ra];
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    add_ok_r   <= add_ok_nxt;
    top_v_r    <= top_v_nxt;
    top_cur_r  <= top_cur_nxt;
    dv_r       <= dv_nxt;
    dp_r       <= dp_nxt;
    ev_r       <= ev_nxt;
    o_vertex_r <= o_vertex_nxt;
    o_parent_r <= o_parent_nxt;
    o_disc_r   <= o_disc_nxt;
    o_fin_r    <= o_fin_nxt;
    o_cycle_r  <= o_cycle_nxt;
    o_last_r   <= o_last_nxt;
    o_bf_r     <= o_bf_nxt;
    o_bt_r     <= o_bt_nxt;
  end

  dts_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_head (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_addr(head_ra), .rd_data(head_q)
  );

  dts_ram #(.WIDTH(VW + CW), .DEPTH(MAX_EDGES)) u_edge (
    .clk(clk), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
    .rd_addr(edge_ra), .rd_data(edge_q)
  );

  dts_ram #(.WIDTH(VW + CW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
    .rd_addr(stk_ra), .rd_data(stk_q)
  );

  dts_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_order (
    .clk(clk), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(top_v_r),
    .rd_addr(ord_ra), .rd_data(ord_q)
  );

  dts_ram #(.WIDTH(DW + TW), .DEPTH(MAX_VERTICES)) u_info (
    .clk(clk), .wr_en(info_we), .wr_addr(dv_r), .wr_data(info_wd),
    .rd_addr(ord_q), .rd_data(info_q)
  );

  dts_ram #(.WIDTH(TW), .DEPTH(MAX_VERTICES)) u_fin (
    .clk(clk), .wr_en(fin_we), .wr_addr(fin_wa), .wr_data(fin_wd),
    .rd_addr(ord_q), .rd_data(fin_q)
  );

  assign out_strobe         = out_strobe_r;
  assign out_vertex         = o_vertex_r;
  assign out_parent         = o_parent_r;
  assign out_discovery_time = TIME_W'(o_disc_r);
  assign out_finish_time    = TIME_W'(o_fin_r);
  assign out_cycle_found    = o_cycle_r;
  assign out_back_edge_from = o_bf_r;
  assign out_back_edge_to   = o_bt_r;
  assign out_last           = o_last_r;

endmodule
